[hdl/stereo_biquad_df1_filter_defines.svh]
// ----------------------------------------------------------------------------
// Stereo biquad filter assertion macros
// Shared property wrappers for the port checker. Each use expects clk_i and
// rst_ni in scope and is disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_DF1_FILTER_DEFINES_SVH
`define STEREO_BIQUAD_DF1_FILTER_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define SBQF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sbqf: property failed");

// Check that a condition leads to a consequence in the next cycle
`define SBQF_ASSERT_NEXT(lbl, ante, cons) `SBQF_ASSERT(lbl, (ante) |=> (cons))

`endif

[hdl/sbqf_pkg.sv]
// ----------------------------------------------------------------------------
// sbqf_pkg
// Widths, types and register codes of the stereo direct form I biquad.
// ----------------------------------------------------------------------------
`default_nettype none

package sbqf_pkg;

  // Block configuration
  localparam int CHANNELS       = 2;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int COEF_BITS      = 24;

  // Derived widths
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W      = PROD_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [CH_AW-1:0]              ch_idx_t;

  // One history memory entry: two past inputs and two past outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ON = 3'd0,
    REG_COEF_FF0  = 3'd1,
    REG_COEF_FF1  = 3'd2,
    REG_COEF_FF2  = 3'd3,
    REG_COEF_FB1  = 3'd4,
    REG_COEF_FB2  = 3'd5
  } reg_idx_e;

  // Map a channel tag onto a history entry; tags beyond the channel count use entry 0
  function automatic ch_idx_t ch_index(input logic tag);
    ch_idx_t idx;
    idx = '0;
    if (CHANNELS > 1) begin
      idx = ch_idx_t'(tag);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hdl/stereo_biquad_df1_filter.sv]
// ----------------------------------------------------------------------------
// stereo_biquad_df1_filter
// Second-order IIR filter in direct form I for up to two audio channels.
//
// Usage:
//   s_axis carries one sample per transfer, tuser selects the channel.
//   m_axis returns one filtered sample per input, same channel tag, in order.
//   Coefficients and filter_on are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i while the block is idle. With filter_on low, samples pass
//   through unchanged and the history of every channel is cleared.
//   A sample passes stage 1, stage 2 and the output register to m_axis.
//   Throughput: one sample per cycle while the channel tag alternates and
//   m_axis does not stall; a sample of the channel held in stage 1 waits
//   until that one moves on, set by the read-modify-write loop on the
//   history memory (read, multiply stage, sum and write back).
//   Reset clears configuration, empties the pipeline and marks all history
//   entries as zero. When m_axis stalls, the whole pipeline holds and
//   s_axis_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_df1_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sbqf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbqf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sbqf_pkg::TDATA_W-1:0]    s_axis_tdata,  // sample_in
  input  logic                            s_axis_tuser,  // channel
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sbqf_pkg::TDATA_W-1:0]    m_axis_tdata,  // sample_out
  output logic                            m_axis_tuser   // channel_out
);

  localparam int SB = sbqf_pkg::SAMPLE_BITS;

  localparam sbqf_pkg::acc_t RND_HALF =
    sbqf_pkg::acc_t'(1) << (sbqf_pkg::COEF_FRAC_BITS - 1);
  localparam sbqf_pkg::acc_t SAT_MAX =
    {{(sbqf_pkg::ACC_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam sbqf_pkg::acc_t SAT_MIN =
    {{(sbqf_pkg::ACC_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

  // configuration registers
  logic                  filter_on_q;
  sbqf_pkg::coef_t       ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;

  // handshake and pipeline control
  logic                  advance;
  logic                  hazard;
  logic                  in_acc;
  sbqf_pkg::ch_idx_t     in_ch;

  // history memory and its valid bits
  sbqf_pkg::hist_t       hist_mem [sbqf_pkg::CHANNELS];
  logic                  ent_vld_q [sbqf_pkg::CHANNELS];
  sbqf_pkg::hist_t       rd_data_q;
  logic                  rd_vld_q;

  // last write-back, for forwarding
  logic                  wb_vld_q;
  logic                  wb_clr_q;
  sbqf_pkg::ch_idx_t     wb_ch_q;
  sbqf_pkg::hist_t       wb_hist_q;

  // stage 1: history lookup and products
  logic                  s1_vld_q;
  sbqf_pkg::ch_idx_t     s1_ch_q;
  logic                  s1_tag_q;
  sbqf_pkg::sample_t     s1_x_q;
  logic                  fwd_hit;
  sbqf_pkg::hist_t       s1_hist;

  // stage 2: sum, round, saturate, write back
  logic                  s2_vld_q;
  sbqf_pkg::ch_idx_t     s2_ch_q;
  logic                  s2_tag_q;
  sbqf_pkg::sample_t     s2_x_q, s2_x1_q, s2_y1_q;
  sbqf_pkg::prod_t       s2_p0_q, s2_p1_q, s2_p2_q, s2_p3_q, s2_p4_q;
  sbqf_pkg::acc_t        acc_sum;
  sbqf_pkg::acc_t        acc_shift;
  sbqf_pkg::acc_t        acc_sat;
  sbqf_pkg::sample_t     y_new;
  sbqf_pkg::hist_t       new_hist;
  logic                  s2_fire;

  // output register
  logic                  out_vld_q;
  logic                  out_tag_q;
  logic [SB-1:0]         out_sample_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_on_q <= 1'b0;
      ff0_q       <= '0;
      ff1_q       <= '0;
      ff2_q       <= '0;
      fb1_q       <= '0;
      fb2_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (sbqf_pkg::reg_idx_e'(cfg_idx_i))
        sbqf_pkg::REG_FILTER_ON: filter_on_q <= cfg_data_i[0];
        sbqf_pkg::REG_COEF_FF0:  ff0_q <= sbqf_pkg::coef_t'(cfg_data_i);
        sbqf_pkg::REG_COEF_FF1:  ff1_q <= sbqf_pkg::coef_t'(cfg_data_i);
        sbqf_pkg::REG_COEF_FF2:  ff2_q <= sbqf_pkg::coef_t'(cfg_data_i);
        sbqf_pkg::REG_COEF_FB1:  fb1_q <= sbqf_pkg::coef_t'(cfg_data_i);
        sbqf_pkg::REG_COEF_FB2:  fb2_q <= sbqf_pkg::coef_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance when the output register is free; hold a sample whose channel is in stage 1
  assign advance       = !out_vld_q || m_axis_tready;
  assign in_ch         = sbqf_pkg::ch_index(s_axis_tuser);
  assign hazard        = s1_vld_q && (s1_ch_q == in_ch);
  assign s_axis_tready = advance && !hazard;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Read the history entry of the incoming channel
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= hist_mem[in_ch];
    end
  end

  // Write back the updated history entry
  always_ff @(posedge clk_i) begin
    if (s2_fire && filter_on_q) begin
      hist_mem[s2_ch_q] <= new_hist;
    end
  end

  // Track which entries hold written history; pass-through clears them all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbqf_pkg::CHANNELS; i++) begin
        ent_vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_q <= ent_vld_q[in_ch];
      end
      if (s2_fire) begin
        if (filter_on_q) begin
          ent_vld_q[s2_ch_q] <= 1'b1;
        end else begin
          for (int i = 0; i < sbqf_pkg::CHANNELS; i++) begin
            ent_vld_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  // Capture the latest write-back for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
      wb_clr_q <= 1'b0;
    end else if (s2_fire) begin
      wb_vld_q <= 1'b1;
      wb_clr_q <= !filter_on_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      wb_ch_q   <= s2_ch_q;
      wb_hist_q <= new_hist;
    end
  end

  // Stage 1 control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q  <= in_ch;
      s1_tag_q <= s_axis_tuser;
      s1_x_q   <= sbqf_pkg::sample_t'(s_axis_tdata[SB-1:0]);
    end
  end

  // Resolve history: forward the last write-back, else memory, else zero
  assign fwd_hit = wb_vld_q && (wb_clr_q || (wb_ch_q == s1_ch_q));

  always_comb begin
    if (fwd_hit) begin
      s1_hist = wb_clr_q ? '0 : wb_hist_q;
    end else if (rd_vld_q) begin
      s1_hist = rd_data_q;
    end else begin
      s1_hist = '0;
    end
  end

  // Stage 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // Form the five products and register them
  always_ff @(posedge clk_i) begin
    if (advance && s1_vld_q) begin
      s2_ch_q  <= s1_ch_q;
      s2_tag_q <= s1_tag_q;
      s2_x_q   <= s1_x_q;
      s2_x1_q  <= s1_hist.x1;
      s2_y1_q  <= s1_hist.y1;
      s2_p0_q  <= sbqf_pkg::prod_t'(ff0_q) * sbqf_pkg::prod_t'(s1_x_q);
      s2_p1_q  <= sbqf_pkg::prod_t'(ff1_q) * sbqf_pkg::prod_t'(s1_hist.x1);
      s2_p2_q  <= sbqf_pkg::prod_t'(ff2_q) * sbqf_pkg::prod_t'(s1_hist.x2);
      s2_p3_q  <= sbqf_pkg::prod_t'(fb1_q) * sbqf_pkg::prod_t'(s1_hist.y1);
      s2_p4_q  <= sbqf_pkg::prod_t'(fb2_q) * sbqf_pkg::prod_t'(s1_hist.y2);
    end
  end

  // Sum, round half up and saturate to the sample range
  always_comb begin
    acc_sum = sbqf_pkg::acc_t'(s2_p0_q) + sbqf_pkg::acc_t'(s2_p1_q)
            + sbqf_pkg::acc_t'(s2_p2_q) - sbqf_pkg::acc_t'(s2_p3_q)
            - sbqf_pkg::acc_t'(s2_p4_q);
    acc_shift = (acc_sum + RND_HALF) >>> sbqf_pkg::COEF_FRAC_BITS;
    if (acc_shift > SAT_MAX) begin
      acc_sat = SAT_MAX;
    end else if (acc_shift < SAT_MIN) begin
      acc_sat = SAT_MIN;
    end else begin
      acc_sat = acc_shift;
    end
    y_new = sbqf_pkg::sample_t'(acc_sat[SB-1:0]);
  end

  // Shift the history by one sample
  always_comb begin
    new_hist.x1 = s2_x_q;
    new_hist.x2 = s2_x1_q;
    new_hist.y1 = y_new;
    new_hist.y2 = s2_y1_q;
  end

  assign s2_fire = advance && s2_vld_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_tag_q    <= s2_tag_q;
      out_sample_q <= filter_on_q ? y_new : s2_x_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_tag_q;
  assign m_axis_tdata  = sbqf_pkg::TDATA_W'(out_sample_q);

endmodule

`default_nettype wire

[hdl/sbqf_checker.sv]
// ----------------------------------------------------------------------------
// sbqf_checker
// Port-level checks of the stereo biquad filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_biquad_df1_filter_defines.svh"

module sbqf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,  // channel
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbqf_pkg::TDATA_W-1:0]    m_axis_tdata,  // sample_out
  input logic                            m_axis_tuser   // channel_out
);

  logic in_xfer;
  logic out_stall;
  logic out_free;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // Hold a stalled result
  `SBQF_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A stalled output back-pressures the input
  `SBQF_ASSERT(a_stall_blocks_input, out_stall |-> !s_axis_tready)

  // An input transfer with the output free while it sits in stage 1 and stage 2 shows a result
  `SBQF_ASSERT(a_latency, in_xfer ##1 out_free ##1 out_free |=> m_axis_tvalid)

  // Two same-channel transfers never land on adjacent cycles
  `SBQF_ASSERT_NEXT(a_same_ch_gap, in_xfer, !(in_xfer && (s_axis_tuser == $past(s_axis_tuser))))

endmodule

bind stereo_biquad_df1_filter sbqf_checker u_sbqf_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Stereo biquad filter testbench
// Streams tagged samples through stereo_biquad_df1_filter and compares every
// output transfer against a cycle-free fixed-point biquad predictor that keeps
// its own per-channel history and coefficient copy. Directed tests cover
// pass-through, unused register indexes, rounding, saturation and history
// clearing; random phases then sweep coefficient sets with idle and stall gaps.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths and types of the block
  localparam int CHANNELS       = sbqf_pkg::CHANNELS;
  localparam int SAMPLE_BITS    = sbqf_pkg::SAMPLE_BITS;
  localparam int COEF_FRAC_BITS = sbqf_pkg::COEF_FRAC_BITS;
  localparam int COEF_BITS      = sbqf_pkg::COEF_BITS;
  localparam int CFG_IDX_W      = sbqf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = sbqf_pkg::CFG_DATA_W;
  localparam int TDATA_W        = sbqf_pkg::TDATA_W;

  typedef sbqf_pkg::coef_t   coef_t;
  typedef sbqf_pkg::sample_t sample_t;

  // Register indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
  localparam coef_t  COEF_ONE   = coef_t'(1 << COEF_FRAC_BITS);
  localparam coef_t  COEF_HALF  = coef_t'(1 << (COEF_FRAC_BITS - 1));
  localparam coef_t  COEF_MAX   = coef_t'({1'b0, {(COEF_BITS-1){1'b1}}});
  localparam coef_t  COEF_MIN   = coef_t'({1'b1, {(COEF_BITS-1){1'b0}}});
  localparam sample_t SMP_MAX   = sample_t'(SAMPLE_MAX);
  localparam sample_t SMP_MIN   = sample_t'(SAMPLE_MIN);

  typedef struct {
    logic    tag;
    sample_t sample;
  } filtered_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;   // sample_in
  logic                  s_axis_tuser = 1'b0; // channel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;        // sample_out
  logic                  m_axis_tuser;        // channel_out

  // Predictor state: configuration and per-channel history
  logic    bq_on;
  coef_t   bq_ff0, bq_ff1, bq_ff2, bq_fb1, bq_fb2;
  sample_t hist_x1 [2];
  sample_t hist_x2 [2];
  sample_t hist_y1 [2];
  sample_t hist_y2 [2];

  filtered_t pending_outputs [$];
  int        mismatch_count = 0;
  bit        send_idle_en = 1'b1;
  bit        recv_stall_en = 1'b1;

  stereo_biquad_df1_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop for a hung pipeline
  initial begin
    #400_000;
    $display("FAIL stereo_biquad_df1_filter");
    $finish;
  end

  // Clear the history of every channel
  function automatic void clear_history();
    for (int c = 0; c < 2; c++) begin
      hist_x1[c] = '0;
      hist_x2[c] = '0;
      hist_y1[c] = '0;
      hist_y2[c] = '0;
    end
  endfunction

  // Filter one sample and advance the history of its channel
  function automatic sample_t filter_sample(input logic tag, input sample_t x);
    longint acc;
    longint y;
    int     ch;
    ch = (int'(tag) < CHANNELS) ? int'(tag) : 0;
    if (!bq_on) begin
      clear_history();
      return x;
    end
    acc = longint'(bq_ff0) * longint'(x)
        + longint'(bq_ff1) * longint'(hist_x1[ch])
        + longint'(bq_ff2) * longint'(hist_x2[ch])
        - longint'(bq_fb1) * longint'(hist_y1[ch])
        - longint'(bq_fb2) * longint'(hist_y2[ch]);
    y = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    hist_x2[ch] = hist_x1[ch];
    hist_x1[ch] = x;
    hist_y2[ch] = hist_y1[ch];
    hist_y1[ch] = sample_t'(y);
    return sample_t'(y);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Drive one register write; the enable stays high until end_writes
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      sbqf_pkg::REG_FILTER_ON: bq_on  = data[0];
      sbqf_pkg::REG_COEF_FF0:  bq_ff0 = coef_t'(data);
      sbqf_pkg::REG_COEF_FF1:  bq_ff1 = coef_t'(data);
      sbqf_pkg::REG_COEF_FF2:  bq_ff2 = coef_t'(data);
      sbqf_pkg::REG_COEF_FB1:  bq_fb1 = coef_t'(data);
      sbqf_pkg::REG_COEF_FB2:  bq_fb2 = coef_t'(data);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load every register; junk in the upper bits of filter_on must be ignored
  task automatic load_settings(input logic on, input coef_t f0, input coef_t f1,
                               input coef_t f2, input coef_t b1, input coef_t b2);
    logic [CFG_DATA_W-1:0] on_word;
    on_word    = CFG_DATA_W'($urandom);
    on_word[0] = on;
    write_register(sbqf_pkg::REG_FILTER_ON, on_word);
    write_register(sbqf_pkg::REG_COEF_FF0, f0);
    write_register(sbqf_pkg::REG_COEF_FF1, f1);
    write_register(sbqf_pkg::REG_COEF_FF2, f2);
    write_register(sbqf_pkg::REG_COEF_FB1, b1);
    write_register(sbqf_pkg::REG_COEF_FB2, b2);
    end_writes();
  endtask

  // Offer one sample, hold it until the transfer, then predict its output
  task automatic send_sample(input logic tag, input sample_t x);
    int                 gap;
    logic [TDATA_W-1:0] word;
    gap = 0;
    if (send_idle_en) begin
      while ($urandom_range(99) < 24) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word = '0;
    word[SAMPLE_BITS-1:0] = x;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= tag;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outputs.push_back('{tag: tag, sample: filter_sample(tag, x)});
  endtask

  // Stop offering and wait for every predicted output
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Random ready on the output side
  always @(posedge clk_i) begin
    m_axis_tready <= !recv_stall_en || ($urandom_range(99) >= 24);
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk_i) begin : check_output
    filtered_t          want;
    logic [TDATA_W-1:0] want_word;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("output with nothing pending, tuser=%0b tdata=%h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        want = pending_outputs.pop_front();
        want_word = '0;
        want_word[SAMPLE_BITS-1:0] = want.sample;
        if (m_axis_tuser !== want.tag) begin
          report_mismatch($sformatf("channel got %0b want %0b", m_axis_tuser, want.tag));
        end
        if (m_axis_tdata !== want_word) begin
          report_mismatch($sformatf("sample ch%0b got %h want %h",
                                    want.tag, m_axis_tdata, want_word));
        end
      end
    end
  end

  // After reset the filter is off: samples pass through
  task automatic test_reset_passthrough();
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b0, '0);
    send_sample(1'b1, sample_t'(-1));
    send_sample(1'b0, sample_t'(24'h555555));
    send_sample(1'b1, sample_t'(24'haaaaaa));
    drain_outputs();
  endtask

  // Writes to indexes past the last register must change nothing
  task automatic test_spare_index();
    load_settings(1'b1, COEF_ONE, '0, '0, '0, '0);
    write_register(REG_SPARE_6, '1);
    write_register(REG_SPARE_7, '1);
    end_writes();
    send_sample(1'b0, sample_t'(24'h123456));
    send_sample(1'b1, sample_t'(-24'sd98765));
    drain_outputs();
  endtask

  // Impulses per channel; half-LSB ties round toward plus infinity
  task automatic test_impulse_rounding();
    load_settings(1'b1, COEF_HALF, COEF_ONE, -COEF_HALF, coef_t'(-24'sh0c0000),
                  coef_t'(24'sh040000));
    send_sample(1'b0, sample_t'(1));
    send_sample(1'b1, sample_t'(-1));
    send_sample(1'b0, '0);
    send_sample(1'b0, '0);
    send_sample(1'b1, '0);
    send_sample(1'b1, sample_t'(3));
    send_sample(1'b0, sample_t'(-3));
    drain_outputs();
  endtask

  // Extreme coefficients drive the output into both rails
  task automatic test_saturation();
    load_settings(1'b1, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b0, SMP_MIN);
    send_sample(1'b0, SMP_MAX);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b1, SMP_MIN);
    send_sample(1'b1, SMP_MAX);
    drain_outputs();
  endtask

  // Turning the filter off passes samples and wipes all history
  task automatic test_off_clears_history();
    load_settings(1'b0, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample(1'b0, sample_t'(12345));
    send_sample(1'b1, sample_t'(-777));
    drain_outputs();
    load_settings(1'b1, '0, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE);
    send_sample(1'b0, '0);
    send_sample(1'b1, '0);
    drain_outputs();
  endtask

  // Random traffic over phases with different coefficient sets
  task automatic test_random_traffic(input int phases, input int per_phase);
    coef_t   c [5];
    logic    on;
    sample_t x;
    int      kind;
    for (int p = 0; p < phases; p++) begin
      kind = (p < 2) ? p : $urandom_range(2, 4);
      on = (p < 2) || ($urandom_range(4) != 0);
      for (int k = 0; k < 5; k++) begin
        case (kind)
          0: c[k] = (k % 2 == 0) ? COEF_MAX : COEF_MIN;
          1: c[k] = (k % 2 == 0) ? COEF_MIN : COEF_MAX;
          2: c[k] = coef_t'($urandom);
          default: c[k] = coef_t'(int'($urandom_range(24'h200000)) - 24'h100000);
        endcase
      end
      // Keep gentle sets close to a stable low-order filter
      if (kind >= 3) begin
        c[3] = coef_t'(int'($urandom_range(24'h380000)) - 24'h1c0000);
        c[4] = coef_t'($urandom_range(24'h0e0000));
      end
      load_settings(on, c[0], c[1], c[2], c[3], c[4]);
      // One phase runs with both sides at full rate
      send_idle_en  = (p != 3);
      recv_stall_en = (p != 3);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) < 7) x = sample_t'($urandom);
        else x = sample_t'(int'($urandom_range(255)) - 128);
        send_sample(1'($urandom), x);
      end
      drain_outputs();
    end
    send_idle_en  = 1'b1;
    recv_stall_en = 1'b1;
  endtask

  initial begin
    bq_on  = 1'b0;
    bq_ff0 = '0;
    bq_ff1 = '0;
    bq_ff2 = '0;
    bq_fb1 = '0;
    bq_fb2 = '0;
    clear_history();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_passthrough();
    test_spare_index();
    test_impulse_rounding();
    test_saturation();
    test_off_clears_history();
    test_random_traffic(10, 195);

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS stereo_biquad_df1_filter");
    end else begin
      $display("FAIL stereo_biquad_df1_filter");
    end
    $finish;
  end

endmodule
